>>> rtl/subnet_packet_rate_limiter_top_assert.svh
// assertion macros for the subnet packet rate limiter
// used by the controller; no other dependencies
`ifndef SUBNET_PACKET_RATE_LIMITER_TOP_ASSERT_SVH
`define SUBNET_PACKET_RATE_LIMITER_TOP_ASSERT_SVH
`define SPRL_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("label failed");
`define SPRL_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("label failed");
`endif

>>> rtl/sprl_pkg.sv
// types and constants for the subnet packet rate limiter
// no dependencies
`default_nettype none
package sprl_pkg;
	localparam logic [1:0] CMD_PACKET = 2'd0;
	localparam logic [1:0] CMD_WR_V4 = 2'd1;
	localparam logic [1:0] CMD_WR_V6 = 2'd2;
	localparam logic [1:0] CMD_REMOVE = 2'd3;
	localparam logic [31:0] INTERVAL_RESET = 32'd1000000000;
	localparam logic [32:0] COUNT_MAX = {33{1'b1}};

	typedef enum logic [1:0] {ST_IDLE, ST_MATCH, ST_COUNT, ST_OUT} state_t;

	typedef struct packed {
		logic cfg_wr;
		logic load;
		logic match;
		logic count;
	} ctl_t;

	typedef struct packed {
		logic is_pkt;
	} sts_t;
endpackage
`default_nettype wire

>>> rtl/subnet_packet_rate_limiter_top.sv
// Subnet packet rate limiter. One request in flight at a time: a request is taken,
// the rule table is matched in parallel (or written) in the next cycle, the hit rule's
// counter is updated in the cycle after, and the registered result is then offered
// until taken; the next request is taken the cycle after the result is taken. Reset
// clears the table at once. Requests wait through ST_MATCH, ST_COUNT and ST_OUT.
// The interval register is written only while idle with no request offered.
// depends on sprl_pkg, sprl_datapath, sprl_ctrl
`default_nettype none
module subnet_packet_rate_limiter_top #(
	parameter int RULES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] cmd,
	input wire logic [3:0] rule_index,
	input wire logic is_v6,
	input wire logic [63:0] addr_hi,
	input wire logic [63:0] addr_lo,
	input wire logic [63:0] mask_hi,
	input wire logic [63:0] mask_lo,
	input wire logic [31:0] packet_limit,
	input wire logic [63:0] now_ns,
	output logic out_valid,
	input wire logic out_stall,
	output logic verdict,
	output logic matched,
	output logic [3:0] hit_index
);
	import sprl_pkg::*;
	ctl_t ctl;
	sts_t sts;

	sprl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
		.out_stall(out_stall), .sts(sts), .ctl(ctl)
	);

	sprl_datapath #(.RULES(RULES)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .cfg_data(cfg_data),
		.cmd(cmd), .rule_index(rule_index), .is_v6(is_v6),
		.addr_hi(addr_hi), .addr_lo(addr_lo), .mask_hi(mask_hi), .mask_lo(mask_lo),
		.packet_limit(packet_limit), .now_ns(now_ns),
		.verdict(verdict), .matched(matched), .hit_index(hit_index)
	);
endmodule
`default_nettype wire

>>> rtl/sprl_datapath.sv
// interval register, rule table, parallel match, first-hit select and counter update
// depends on sprl_pkg
`default_nettype none
module sprl_datapath #(
	parameter int RULES = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire sprl_pkg::ctl_t ctl,
	output sprl_pkg::sts_t sts,
	input wire logic [31:0] cfg_data,
	input wire logic [1:0] cmd,
	input wire logic [3:0] rule_index,
	input wire logic is_v6,
	input wire logic [63:0] addr_hi,
	input wire logic [63:0] addr_lo,
	input wire logic [63:0] mask_hi,
	input wire logic [63:0] mask_lo,
	input wire logic [31:0] packet_limit,
	input wire logic [63:0] now_ns,
	output logic verdict,
	output logic matched,
	output logic [3:0] hit_index
);
	import sprl_pkg::*;
	localparam int IW = (RULES > 1) ? $clog2(RULES) : 1;

	logic [31:0] interval_q;
	logic [RULES-1:0] present_q;
	logic [31:0] v4n_q [RULES];
	logic [31:0] v4m_q [RULES];
	logic [63:0] v6nu_q [RULES];
	logic [63:0] v6nl_q [RULES];
	logic [63:0] v6mu_q [RULES];
	logic [63:0] v6ml_q [RULES];
	logic [31:0] lim_q [RULES];
	logic [32:0] cnt_q [RULES];
	logic [63:0] wend_q [RULES];

	logic [1:0] cmd_q;
	logic [3:0] idx_q;
	logic v6_q;
	logic [63:0] ahi_q, alo_q, mhi_q, mlo_q, now_q;
	logic [31:0] plim_q;

	logic found_s1;
	logic [IW-1:0] hidx_s1;

	logic [RULES-1:0] hit;
	logic found;
	logic [IW-1:0] hidx;
	logic [32:0] cnt_inc;
	logic idx_ok;
	logic [IW-1:0] widx;

	assign sts.is_pkt = (cmd_q == CMD_PACKET);
	assign idx_ok = ({3'b000, idx_q} < 7'(RULES));
	assign widx = IW'(idx_q);

	always_comb begin
		for (int k = 0; k < RULES; k++) begin
			if (!v6_q)
				hit[k] = (alo_q[31:0] == 32'd0) || ((v4n_q[k] != 32'd0) &&
					((alo_q[31:0] & v4m_q[k]) == v4n_q[k]));
			else
				hit[k] = v6mu_q[k][63] && ((ahi_q & v6mu_q[k]) == v6nu_q[k]) &&
					((alo_q & v6ml_q[k]) == v6nl_q[k]);
		end
	end

	// first hit before the first absent rule
	always_comb begin : first_hit
		logic stop;
		stop = 1'b0;
		found = 1'b0;
		hidx = '0;
		for (int k = 0; k < RULES; k++) begin
			if (!stop) begin
				if (!present_q[k]) begin
					stop = 1'b1;
				end else if (hit[k]) begin
					stop = 1'b1;
					found = 1'b1;
					hidx = IW'(k);
				end
			end
		end
	end

	assign cnt_inc = (cnt_q[hidx_s1] < COUNT_MAX) ? cnt_q[hidx_s1] + 33'd1 : COUNT_MAX;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			idx_q <= rule_index;
			v6_q <= is_v6;
			ahi_q <= addr_hi;
			alo_q <= addr_lo;
			mhi_q <= mask_hi;
			mlo_q <= mask_lo;
			plim_q <= packet_limit;
			now_q <= now_ns;
		end
		if (ctl.match) begin
			found_s1 <= found && (cmd_q == CMD_PACKET);
			hidx_s1 <= hidx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (ctl.cfg_wr) begin
			interval_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			verdict <= 1'b0;
			matched <= 1'b0;
			hit_index <= '0;
			for (int k = 0; k < RULES; k++) begin
				v4n_q[k] <= '0;
				v4m_q[k] <= '0;
				v6nu_q[k] <= '0;
				v6nl_q[k] <= '0;
				v6mu_q[k] <= '0;
				v6ml_q[k] <= '0;
				lim_q[k] <= '0;
				cnt_q[k] <= '0;
				wend_q[k] <= '0;
			end
		end else begin
			if (ctl.match && cmd_q != CMD_PACKET && idx_ok) begin
				case (cmd_q)
					CMD_WR_V4: begin
						v4n_q[widx] <= alo_q[31:0];
						v4m_q[widx] <= mlo_q[31:0];
						lim_q[widx] <= plim_q;
						present_q[widx] <= 1'b1;
						cnt_q[widx] <= '0;
						wend_q[widx] <= '0;
					end
					CMD_WR_V6: begin
						v6nu_q[widx] <= ahi_q;
						v6nl_q[widx] <= alo_q;
						v6mu_q[widx] <= mhi_q;
						v6ml_q[widx] <= mlo_q;
						present_q[widx] <= 1'b1;
						cnt_q[widx] <= '0;
						wend_q[widx] <= '0;
					end
					CMD_REMOVE: begin
						v4n_q[widx] <= '0;
						v4m_q[widx] <= '0;
						v6nu_q[widx] <= '0;
						v6nl_q[widx] <= '0;
						v6mu_q[widx] <= '0;
						v6ml_q[widx] <= '0;
						lim_q[widx] <= '0;
						present_q[widx] <= 1'b0;
						cnt_q[widx] <= '0;
						wend_q[widx] <= '0;
					end
					default: begin
					end
				endcase
			end
			// counter read-modify-write when ctl.count is set
			if (ctl.count) begin
				if (found_s1) begin
					matched <= 1'b1;
					hit_index <= 4'(hidx_s1);
					if (now_q > wend_q[hidx_s1]) begin
						wend_q[hidx_s1] <= now_q + {32'd0, interval_q};
						cnt_q[hidx_s1] <= 33'd1;
						verdict <= 1'b0;
					end else begin
						cnt_q[hidx_s1] <= cnt_inc;
						verdict <= (cnt_inc > {1'b0, lim_q[hidx_s1]});
					end
				end else begin
					verdict <= 1'b0;
					matched <= 1'b0;
					hit_index <= '0;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/sprl_ctrl.sv
// handshake controller: accept, match, update, present result, config writes
// depends on sprl_pkg and the assertion header
`default_nettype none
`include "subnet_packet_rate_limiter_top_assert.svh"
module sprl_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire sprl_pkg::sts_t sts,
	output sprl_pkg::ctl_t ctl
);
	import sprl_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// load: take request; match: table match or write; count: counter update
	always_comb begin
		state_d = state_q;
		ctl = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		cfg_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cfg_ready = !in_valid;
				ctl.cfg_wr = cfg_valid && !in_valid;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				ctl.match = 1'b1;
				state_d = ST_COUNT;
			end
			ST_COUNT: begin
				ctl.count = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`SPRL_ASSERT_NEXT(a_load_then_match, clk, arst_n, ctl.load, state_q == ST_MATCH)
	`SPRL_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, in_stall)
	`SPRL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`SPRL_ASSERT_IMP(a_cfg_idle, clk, arst_n, ctl.cfg_wr, !ctl.load)
	`SPRL_ASSERT_IMP(a_pkt_known, clk, arst_n, ctl.match, !$isunknown(sts.is_pkt))
endmodule
`default_nettype wire
